// ===== hw/rtl/epc_pkg.sv =====
package epc_pkg;

  localparam logic [15:0] TypeVlan  = 16'h8100;
  localparam logic [15:0] TypeIpv4  = 16'h0800;
  localparam logic [15:0] TypePnDcp = 16'h8892;
  localparam logic [15:0] TypeLldp  = 16'h88CC;

  localparam logic [3:0] IhlMask = 4'hF;

  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  localparam logic [15:0] PortS7     = 16'd102;
  localparam logic [15:0] PortModbus = 16'd502;
  localparam logic [15:0] PortOpcUa  = 16'd4840;
  localparam logic [15:0] PortEnipT  = 16'd44818;
  localparam logic [15:0] PortEnipU  = 16'd2222;

  localparam int unsigned FifoDepth = 2;

  typedef enum logic [2:0] {
    ClsUnknown  = 3'd0,
    ClsProfinet = 3'd1,
    ClsS7comm   = 3'd2,
    ClsModbus   = 3'd3,
    ClsOpcUa    = 3'd4,
    ClsEnip     = 3'd5
  } proto_class_e;

  typedef struct packed {
    logic [15:0] kept;
    logic [15:0] outer_type;
    logic [15:0] inner_type;
    logic [5:0]  header_bytes;
    logic [7:0]  l4_protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] port_word;
  } frame_rec_t;

  typedef struct packed {
    proto_class_e proto_class;
    logic         ipv4_seen;
    logic         tcp_flag;
    logic         udp_flag;
    logic [15:0]  sport;
    logic [15:0]  dport;
    logic [31:0]  src_addr;
    logic [31:0]  dst_addr;
    logic [15:0]  effective_type;
    logic [2:0]   data_offset;
    logic [15:0]  data_length;
  } result_t;

endpackage

// ===== hw/rtl/epc_front.sv =====
module epc_front import epc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_end_i,
  input  logic        empty_frame_i,
  input  logic [15:0] ether_type_i,
  input  logic        fifo_full_i,
  output logic        push_o,
  output frame_rec_t  rec_o
);

  logic [15:0] limit_q;
  logic        mid_q;
  frame_rec_t  cur_q;
  frame_rec_t  cur;
  frame_rec_t  cur_d;
  logic        accept;
  logic        room;
  logic [15:0] base;
  logic [15:0] p;
  logic [16:0] hb_end;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = fifo_full_i;
  assign accept      = in_valid_i && !fifo_full_i;

  always_comb begin
    if (mid_q) begin
      cur = cur_q;
    end else begin
      cur            = '0;
      cur.outer_type = ether_type_i;
    end
  end

  assign room   = (limit_q == 16'd0) ? (cur.kept != 16'hFFFF) : (cur.kept < limit_q);
  assign base   = (cur.outer_type == TypeVlan) ? 16'd4 : 16'd0;
  assign p      = cur.kept - base;
  assign hb_end = {11'd0, cur.header_bytes} + 17'd4;

  always_comb begin
    cur_d = cur;
    if (!empty_frame_i && room) begin
      if (cur.kept == 16'd2 || cur.kept == 16'd3) begin
        cur_d.inner_type = {cur.inner_type[7:0], data_byte_i};
      end
      if (cur.kept >= base) begin
        if (p == 16'd0) begin
          cur_d.header_bytes = {data_byte_i[3:0] & IhlMask, 2'b00};
        end else if (p == 16'd9) begin
          cur_d.l4_protocol = data_byte_i;
        end else if (p >= 16'd12 && p <= 16'd15) begin
          cur_d.src_addr = {cur.src_addr[23:0], data_byte_i};
        end else if (p >= 16'd16 && p <= 16'd19) begin
          cur_d.dst_addr = {cur.dst_addr[23:0], data_byte_i};
        end
        if (cur.header_bytes >= 6'd20 && p >= {10'd0, cur.header_bytes} &&
            {1'b0, p} < hb_end) begin
          cur_d.port_word = {cur.port_word[23:0], data_byte_i};
        end
      end
      cur_d.kept = cur.kept + 16'd1;
    end
  end

  assign push_o = accept && frame_end_i;
  assign rec_o  = cur_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      mid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (accept) begin
        mid_q <= !frame_end_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q <= cur_d;
    end
  end

endmodule

// ===== hw/rtl/epc_fifo.sv =====
module epc_fifo import epc_pkg::*; #(
  parameter int unsigned Depth = FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  frame_rec_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output frame_rec_t data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  frame_rec_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q;
  logic [PtrW-1:0]       rd_ptr_q;
  logic [CntW-1:0]       cnt_q;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count above depth");

  a_push_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("transaction pushed into full queue");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not follow push");

endmodule

// ===== hw/rtl/epc_back.sv =====
module epc_back import epc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  frame_rec_t rec_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output result_t    res_o
);

  logic        out_valid_q;
  result_t     res_q;
  result_t     res_d;
  logic        vlan;
  logic [15:0] eff_type;
  logic [15:0] eff_len;
  logic [15:0] l4len;
  logic        ipv4;
  logic        tcp;
  logic        udp;
  logic [15:0] sp;
  logic [15:0] dp;

  assign pop_o = !empty_i && (!out_valid_q || !out_stall_i);

  assign vlan     = (rec_i.outer_type == TypeVlan) && (rec_i.kept >= 16'd4);
  assign eff_type = vlan ? rec_i.inner_type : rec_i.outer_type;
  assign eff_len  = vlan ? rec_i.kept - 16'd4 : rec_i.kept;
  assign l4len    = eff_len - {10'd0, rec_i.header_bytes};
  assign ipv4     = (eff_type == TypeIpv4) && (eff_len >= 16'd20) &&
                    (rec_i.header_bytes >= 6'd20) &&
                    (eff_len >= {10'd0, rec_i.header_bytes});
  assign tcp      = ipv4 && (rec_i.l4_protocol == ProtoTcp) && (l4len >= 16'd20);
  assign udp      = ipv4 && !tcp && (rec_i.l4_protocol == ProtoUdp) && (l4len >= 16'd8);
  assign sp       = (tcp || udp) ? rec_i.port_word[31:16] : 16'd0;
  assign dp       = (tcp || udp) ? rec_i.port_word[15:0] : 16'd0;

  always_comb begin
    res_d                = '0;
    res_d.ipv4_seen      = ipv4;
    res_d.tcp_flag       = tcp;
    res_d.udp_flag       = udp;
    res_d.sport          = sp;
    res_d.dport          = dp;
    res_d.src_addr       = ipv4 ? rec_i.src_addr : 32'd0;
    res_d.dst_addr       = ipv4 ? rec_i.dst_addr : 32'd0;
    res_d.effective_type = eff_type;
    res_d.data_offset    = vlan ? 3'd4 : 3'd0;
    res_d.data_length    = eff_len;
    res_d.proto_class    = ClsUnknown;
    if (tcp) begin
      if (sp == PortS7 || dp == PortS7) begin
        res_d.proto_class = ClsS7comm;
      end else if (sp == PortModbus || dp == PortModbus) begin
        res_d.proto_class = ClsModbus;
      end else if (sp == PortOpcUa || dp == PortOpcUa) begin
        res_d.proto_class = ClsOpcUa;
      end else if (sp == PortEnipT || dp == PortEnipT) begin
        res_d.proto_class = ClsEnip;
      end
    end else if (udp) begin
      if (sp == PortEnipU || dp == PortEnipU) begin
        res_d.proto_class = ClsEnip;
      end
    end else if (eff_type inside {TypePnDcp, TypeLldp}) begin
      res_d.proto_class = ClsProfinet;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.tcp_flag && res_q.udp_flag))
    else $error("both layer-4 flags set");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.ipv4_seen) |-> (res_q.src_addr == 32'd0 && res_q.dst_addr == 32'd0))
    else $error("addresses given without IPv4 header");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(res_q)))
    else $error("stalled result changed");

endmodule

// ===== hw/rtl/ethernet_ipv4_port_classifier_core.sv =====
// out_valid_o rises when a frame's queued record is popped into the output register.
// Throughput: one byte per unstalled cycle; one result per cycle while out_stall_i is low.
// The front stalls only while the FifoDepth-entry frame queue is full.
// Reset (rst_ni low, asynchronous) closes any open frame, empties the queue,
// drops the output valid and sets capture_limit to 0 (keep up to 65535 bytes).
module ethernet_ipv4_port_classifier_core import epc_pkg::*; #(
  parameter int unsigned FifoDepth = epc_pkg::FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_end_i,
  input  logic        empty_frame_i,
  input  logic [15:0] ether_type_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  proto_class_o,
  output logic        ipv4_seen_o,
  output logic        tcp_flag_o,
  output logic        udp_flag_o,
  output logic [15:0] sport_o,
  output logic [15:0] dport_o,
  output logic [31:0] src_addr_o,
  output logic [31:0] dst_addr_o,
  output logic [15:0] effective_type_o,
  output logic [2:0]  data_offset_o,
  output logic [15:0] data_length_o
);

  logic       fifo_push;
  logic       fifo_full;
  frame_rec_t wr_rec;
  frame_rec_t rd_rec;
  logic       fifo_empty;
  logic       fifo_pop;
  result_t    res;

  epc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .frame_end_i   (frame_end_i),
    .empty_frame_i (empty_frame_i),
    .ether_type_i  (ether_type_i),
    .fifo_full_i   (fifo_full),
    .push_o        (fifo_push),
    .rec_o         (wr_rec)
  );

  epc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (wr_rec),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .data_o  (rd_rec)
  );

  epc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (fifo_empty),
    .rec_i       (rd_rec),
    .pop_o       (fifo_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign proto_class_o    = res.proto_class;
  assign ipv4_seen_o      = res.ipv4_seen;
  assign tcp_flag_o       = res.tcp_flag;
  assign udp_flag_o       = res.udp_flag;
  assign sport_o          = res.sport;
  assign dport_o          = res.dport;
  assign src_addr_o       = res.src_addr;
  assign dst_addr_o       = res.dst_addr;
  assign effective_type_o = res.effective_type;
  assign data_offset_o    = res.data_offset;
  assign data_length_o    = res.data_length;

endmodule

// ===== tb/port_class_monitor.sv =====
`timescale 1ns / 1ps

module port_class_monitor import epc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_end_i,
  input  logic        empty_frame_i,
  input  logic [15:0] ether_type_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [2:0]  proto_class_o,
  input  logic        ipv4_seen_o,
  input  logic        tcp_flag_o,
  input  logic        udp_flag_o,
  input  logic [15:0] sport_o,
  input  logic [15:0] dport_o,
  input  logic [31:0] src_addr_o,
  input  logic [31:0] dst_addr_o,
  input  logic [15:0] effective_type_o,
  input  logic [2:0]  data_offset_o,
  input  logic [15:0] data_length_o,
  output logic [31:0] fail_count_o,
  output logic [31:0] verdicts_pending_o,
  output logic [31:0] results_seen_o
);

  logic [15:0] limit_now = '0;
  logic [15:0] kept_bytes = '0;
  logic [15:0] outer_et = '0;
  logic [15:0] inner_et = '0;
  logic [5:0]  ip_hdr_len = '0;
  logic [7:0]  l4_proto = '0;
  logic [31:0] src_ip = '0;
  logic [31:0] dst_ip = '0;
  logic [31:0] l4_ports = '0;
  bit          frame_open = 1'b0;

  result_t     frame_verdicts_q[$];
  result_t     predicted;
  result_t     want;
  bit          produced;
  int unsigned fail_total = 0;
  int unsigned seen_total = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t ns: result mismatch on %s: got %0h, expected %0h",
             $time, what, got, exp_val);
    fail_total++;
  endtask

  task automatic classify_item(input logic [7:0] b, input logic fin, input logic nobyte,
                               input logic [15:0] et, output bit done, output result_t r);
    int unsigned pos;
    int unsigned base;
    int unsigned p;
    int unsigned eff_len;
    int unsigned l4_len;
    bit          vlan;
    bit          tcp;
    bit          udp;
    logic [15:0] eff;
    logic [15:0] sp;
    logic [15:0] dp;
    proto_class_e cls;
    done = 1'b0;
    r = '0;
    if (!frame_open) begin
      kept_bytes = '0;
      inner_et = '0;
      ip_hdr_len = '0;
      l4_proto = '0;
      src_ip = '0;
      dst_ip = '0;
      l4_ports = '0;
      outer_et = et;
      frame_open = 1'b1;
    end
    if (!nobyte && ((limit_now == 16'd0) ? (kept_bytes != 16'hFFFF)
                                         : (kept_bytes < limit_now))) begin
      pos = kept_bytes;
      base = (outer_et == TypeVlan) ? 4 : 0;
      if (pos == 2 || pos == 3)
        inner_et = {inner_et[7:0], b};
      if (pos >= base) begin
        p = pos - base;
        if (p == 0)
          ip_hdr_len = {b[3:0] & IhlMask, 2'b00};
        else if (p == 9)
          l4_proto = b;
        else if (p >= 12 && p <= 15)
          src_ip = {src_ip[23:0], b};
        else if (p >= 16 && p <= 19)
          dst_ip = {dst_ip[23:0], b};
        if (ip_hdr_len >= 20 && p >= ip_hdr_len && p < ip_hdr_len + 4)
          l4_ports = {l4_ports[23:0], b};
      end
      kept_bytes = kept_bytes + 16'd1;
    end
    if (fin) begin
      frame_open = 1'b0;
      done = 1'b1;
      vlan = (outer_et == TypeVlan) && (kept_bytes >= 16'd4);
      eff = vlan ? inner_et : outer_et;
      eff_len = vlan ? kept_bytes - 16'd4 : kept_bytes;
      tcp = 1'b0;
      udp = 1'b0;
      sp = '0;
      dp = '0;
      cls = ClsUnknown;
      if (eff == TypeIpv4) begin
        if (eff_len >= 20 && ip_hdr_len >= 20 && eff_len >= ip_hdr_len) begin
          l4_len = eff_len - ip_hdr_len;
          r.ipv4_seen = 1'b1;
          r.src_addr = src_ip;
          r.dst_addr = dst_ip;
          tcp = (l4_proto == ProtoTcp) && (l4_len >= 20);
          udp = (l4_proto == ProtoUdp) && (l4_len >= 8);
          if (tcp || udp) begin
            sp = l4_ports[31:16];
            dp = l4_ports[15:0];
          end
          if (tcp) begin
            if (sp == PortS7 || dp == PortS7) cls = ClsS7comm;
            else if (sp == PortModbus || dp == PortModbus) cls = ClsModbus;
            else if (sp == PortOpcUa || dp == PortOpcUa) cls = ClsOpcUa;
            else if (sp == PortEnipT || dp == PortEnipT) cls = ClsEnip;
          end else if (udp && (sp == PortEnipU || dp == PortEnipU)) begin
            cls = ClsEnip;
          end
        end
      end else if (eff == TypePnDcp || eff == TypeLldp) begin
        cls = ClsProfinet;
      end
      r.proto_class = cls;
      r.tcp_flag = tcp;
      r.udp_flag = udp;
      r.sport = sp;
      r.dport = dp;
      r.effective_type = eff;
      r.data_offset = vlan ? 3'd4 : 3'd0;
      r.data_length = eff_len[15:0];
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_now = '0;
      frame_open = 1'b0;
      frame_verdicts_q.delete();
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen_total++;
        if (frame_verdicts_q.size() == 0) begin
          report_mismatch("result with none awaited", {29'd0, proto_class_o}, 32'd0);
        end else begin
          want = frame_verdicts_q.pop_front();
          if (proto_class_o !== want.proto_class)
            report_mismatch("proto_class", 32'(proto_class_o), 32'(want.proto_class));
          if (ipv4_seen_o !== want.ipv4_seen)
            report_mismatch("ipv4_seen", 32'(ipv4_seen_o), 32'(want.ipv4_seen));
          if (tcp_flag_o !== want.tcp_flag)
            report_mismatch("tcp_flag", 32'(tcp_flag_o), 32'(want.tcp_flag));
          if (udp_flag_o !== want.udp_flag)
            report_mismatch("udp_flag", 32'(udp_flag_o), 32'(want.udp_flag));
          if (sport_o !== want.sport)
            report_mismatch("sport", 32'(sport_o), 32'(want.sport));
          if (dport_o !== want.dport)
            report_mismatch("dport", 32'(dport_o), 32'(want.dport));
          if (src_addr_o !== want.src_addr)
            report_mismatch("src_addr", src_addr_o, want.src_addr);
          if (dst_addr_o !== want.dst_addr)
            report_mismatch("dst_addr", dst_addr_o, want.dst_addr);
          if (effective_type_o !== want.effective_type)
            report_mismatch("effective_type", 32'(effective_type_o),
                            32'(want.effective_type));
          if (data_offset_o !== want.data_offset)
            report_mismatch("data_offset", 32'(data_offset_o), 32'(want.data_offset));
          if (data_length_o !== want.data_length)
            report_mismatch("data_length", 32'(data_length_o), 32'(want.data_length));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        classify_item(data_byte_i, frame_end_i, empty_frame_i, ether_type_i,
                      produced, predicted);
        if (produced)
          frame_verdicts_q.insert(frame_verdicts_q.size(), predicted);
      end
      if (cfg_valid_i && cfg_ready_o)
        limit_now = cfg_data_i;
    end
    fail_count_o <= fail_total;
    verdicts_pending_o <= frame_verdicts_q.size();
    results_seen_o <= seen_total;
  end

endmodule

// ===== tb/ethernet_ipv4_port_classifier_core_test.sv =====
`timescale 1ns / 1ps

module ethernet_ipv4_port_classifier_core_test import epc_pkg::*; ();

  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned PhaseItems    = 170;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        frame_end_i;
  logic        empty_frame_i;
  logic [15:0] ether_type_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  proto_class_o;
  logic        ipv4_seen_o;
  logic        tcp_flag_o;
  logic        udp_flag_o;
  logic [15:0] sport_o;
  logic [15:0] dport_o;
  logic [31:0] src_addr_o;
  logic [31:0] dst_addr_o;
  logic [15:0] effective_type_o;
  logic [2:0]  data_offset_o;
  logic [15:0] data_length_o;
  logic [31:0] fail_count_o;
  logic [31:0] verdicts_pending_o;
  logic [31:0] results_seen_o;

  logic [7:0]  frame_bytes[$];
  logic [15:0] frame_type;
  logic [15:0] limit_plan [6];
  bit          gaps_on = 1'b1;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  bit          close_empty = 1'b0;
  bit          mix_empties = 1'b0;
  int unsigned items_sent = 0;
  int unsigned limits_written = 0;
  int unsigned quiet_cycles = 0;

  ethernet_ipv4_port_classifier_core dut (.*);

  port_class_monitor u_monitor (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // no transaction on any channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_item(input logic [7:0] b, input logic fin, input logic nobyte,
                           input logic [15:0] et);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    frame_end_i <= fin;
    empty_frame_i <= nobyte;
    ether_type_i <= et;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_bytes(input int from, input int upto);
    logic [15:0] et_now;
    if (frame_bytes.size() == 0) begin
      push_item(8'($urandom), 1'b1, 1'b1, frame_type);
      return;
    end
    for (int i = from; i < upto; i++) begin
      et_now = (i == 0) ? frame_type : 16'($urandom);
      if (mix_empties && $urandom_range(0, 15) == 0)
        push_item(8'($urandom), 1'b0, 1'b1, et_now);
      push_item(frame_bytes[i], (i == frame_bytes.size() - 1) && !close_empty, 1'b0, et_now);
      if (i == frame_bytes.size() - 1 && close_empty)
        push_item(8'($urandom), 1'b1, 1'b1, 16'($urandom));
    end
  endtask

  task automatic write_limit(input logic [15:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdicts_pending_o != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    limits_written++;
  endtask

  task automatic add_byte(input logic [7:0] v);
    frame_bytes.insert(frame_bytes.size(), v);
  endtask

  task automatic build_raw(input logic [15:0] et, input int unsigned n);
    frame_bytes.delete();
    frame_type = et;
    for (int i = 0; i < n; i++) add_byte(8'($urandom));
  endtask

  task automatic build_ipv4(input bit vlan_tag, input logic [3:0] ihl, input logic [7:0] proto,
                            input logic [15:0] sp, input logic [15:0] dp,
                            input int unsigned l4_len, input int unsigned cut);
    int unsigned hdr;
    frame_bytes.delete();
    frame_type = vlan_tag ? TypeVlan : TypeIpv4;
    if (vlan_tag) begin
      add_byte(8'($urandom));
      add_byte(8'($urandom));
      add_byte(TypeIpv4[15:8]);
      add_byte(TypeIpv4[7:0]);
    end
    hdr = (ihl < 4'd5) ? 20 : ihl * 4;
    for (int i = 0; i < hdr; i++)
      add_byte(i == 0 ? {4'h4, ihl} : (i == 9 ? proto : 8'($urandom)));
    for (int i = 0; i < l4_len; i++) begin
      case (i)
        0:       add_byte(sp[15:8]);
        1:       add_byte(sp[7:0]);
        2:       add_byte(dp[15:8]);
        3:       add_byte(dp[7:0]);
        default: add_byte(8'($urandom));
      endcase
    end
    while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
  endtask

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 9))
      0:       return PortS7;
      1:       return PortModbus;
      2:       return PortOpcUa;
      3:       return PortEnipT;
      4:       return PortEnipU;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_frame();
    int unsigned kind;
    int unsigned l4_len;
    logic [7:0]  proto;
    logic [3:0]  ihl;
    logic [15:0] pn_type;
    kind = $urandom_range(0, 99);
    close_empty = ($urandom_range(0, 9) == 0);
    mix_empties = ($urandom_range(0, 7) == 0);
    ihl = ($urandom_range(0, 4) != 0) ? 4'd5 : 4'($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: proto = ProtoTcp;
      4, 5, 6, 7: proto = ProtoUdp;
      default:    proto = 8'($urandom);
    endcase
    if ($urandom_range(0, 3) != 0)
      l4_len = ((proto == ProtoTcp) ? 20 : 8) + $urandom_range(0, 6);
    else
      l4_len = $urandom_range(0, 24);
    pn_type = $urandom_range(0, 1) ? TypePnDcp : TypeLldp;
    if (kind < 60) begin
      build_ipv4($urandom_range(0, 2) == 0, ihl, proto, pick_port(), pick_port(), l4_len,
                 ($urandom_range(0, 5) == 0) ? $urandom_range(0, 40) : 1000);
    end else if (kind < 70) begin
      if ($urandom_range(0, 1)) begin
        build_raw(pn_type, $urandom_range(0, 12));
      end else begin
        build_raw(TypeVlan, $urandom_range(4, 12));
        frame_bytes[2] = pn_type[15:8];
        frame_bytes[3] = pn_type[7:0];
      end
    end else if (kind < 76) begin
      build_ipv4(1'b1, 4'd5, ProtoTcp, pick_port(), pick_port(), 20, 1000);
      frame_bytes[2] = TypeVlan[15:8];
      frame_bytes[3] = TypeVlan[7:0];
    end else if (kind < 80) begin
      build_raw(TypeVlan, $urandom_range(0, 3));
    end else if (kind < 95) begin
      build_raw(($urandom_range(0, 3) == 0) ? TypeIpv4 : 16'($urandom),
                $urandom_range(0, 30));
    end else begin
      build_raw(16'($urandom), 0);
    end
    send_bytes(0, frame_bytes.size());
  endtask

  initial begin
    int unsigned stop_at;
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    data_byte_i <= '0;
    frame_end_i <= 1'b0;
    empty_frame_i <= 1'b0;
    ether_type_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_limit(16'd0);
    build_raw(TypeIpv4, 0);
    send_bytes(0, 0);
    build_ipv4(1'b0, 4'd5, ProtoTcp, PortS7, 16'd1234, 20, 1000);
    send_bytes(0, frame_bytes.size());
    build_ipv4(1'b1, 4'd5, ProtoTcp, 16'hFFFF, PortModbus, 24, 1000);
    send_bytes(0, frame_bytes.size());
    build_ipv4(1'b0, 4'd6, ProtoTcp, PortOpcUa, 16'h0000, 20, 1000);
    send_bytes(0, frame_bytes.size());
    build_ipv4(1'b1, 4'd5, ProtoTcp, 16'd80, PortEnipT, 20, 1000);
    send_bytes(0, frame_bytes.size());
    build_ipv4(1'b1, 4'd5, ProtoUdp, PortEnipU, 16'd53, 8, 1000);
    send_bytes(0, frame_bytes.size());
    build_ipv4(1'b0, 4'd5, ProtoUdp, PortS7, 16'd53, 8, 1000);
    send_bytes(0, frame_bytes.size());
    build_ipv4(1'b0, 4'd5, ProtoTcp, PortEnipU, 16'd1, 20, 1000);
    send_bytes(0, frame_bytes.size());
    // IHL too small, then IHL past the end of the frame
    build_ipv4(1'b0, 4'd4, ProtoTcp, PortS7, PortS7, 20, 1000);
    send_bytes(0, frame_bytes.size());
    build_ipv4(1'b0, 4'd15, ProtoTcp, PortS7, PortS7, 20, 40);
    send_bytes(0, frame_bytes.size());
    build_ipv4(1'b0, 4'd5, 8'd1, PortS7, PortS7, 20, 1000);
    send_bytes(0, frame_bytes.size());
    build_ipv4(1'b0, 4'd5, ProtoTcp, PortModbus, PortModbus, 19, 1000);
    send_bytes(0, frame_bytes.size());
    build_ipv4(1'b0, 4'd5, ProtoUdp, PortEnipU, PortEnipU, 7, 1000);
    send_bytes(0, frame_bytes.size());
    build_ipv4(1'b0, 4'd5, ProtoTcp, PortS7, PortS7, 20, 19);
    send_bytes(0, frame_bytes.size());
    build_raw(TypePnDcp, 6);
    send_bytes(0, frame_bytes.size());
    build_raw(TypeVlan, 8);
    frame_bytes[2] = TypeLldp[15:8];
    frame_bytes[3] = TypeLldp[7:0];
    send_bytes(0, frame_bytes.size());
    build_raw(TypeVlan, 3);
    send_bytes(0, frame_bytes.size());
    build_ipv4(1'b1, 4'd5, ProtoTcp, PortS7, PortS7, 20, 1000);
    frame_bytes[2] = TypeVlan[15:8];
    frame_bytes[3] = TypeVlan[7:0];
    send_bytes(0, frame_bytes.size());
    build_raw(16'hFFFF, 5);
    foreach (frame_bytes[i]) frame_bytes[i] = 8'hFF;
    send_bytes(0, frame_bytes.size());
    build_raw(16'h0000, 5);
    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    send_bytes(0, frame_bytes.size());
    close_empty = 1'b1;
    build_ipv4(1'b0, 4'd5, ProtoUdp, PortEnipU, 16'd7, 8, 1000);
    send_bytes(0, frame_bytes.size());
    close_empty = 1'b0;
    mix_empties = 1'b1;
    build_ipv4(1'b1, 4'd5, ProtoTcp, 16'd5, PortOpcUa, 20, 1000);
    send_bytes(0, frame_bytes.size());
    mix_empties = 1'b0;

    // limit lowered while a frame is open
    build_ipv4(1'b0, 4'd5, ProtoTcp, PortS7, PortModbus, 20, 1000);
    send_bytes(0, 15);
    write_limit(16'd24);
    send_bytes(15, frame_bytes.size());
    write_limit(16'd1);
    build_raw(TypePnDcp, 3);
    send_bytes(0, frame_bytes.size());

    // receiver holds off while short frames keep coming
    write_limit(16'd0);
    gaps_on = 1'b0;
    hold_req = 1'b1;
    repeat (12) begin
      build_raw(TypeLldp, 2);
      send_bytes(0, frame_bytes.size());
    end
    gaps_on = 1'b1;

    limit_plan[0] = 16'd0;
    limit_plan[1] = 16'($urandom_range(1, 60));
    limit_plan[2] = 16'hFFFF;
    limit_plan[3] = 16'($urandom_range(20, 48));
    limit_plan[4] = 16'($urandom);
    limit_plan[5] = 16'd0;
    for (int ph = 0; ph < 6; ph++) begin
      write_limit(limit_plan[ph]);
      if (ph == 5) begin
        gaps_on = 1'b0;
        idle_on = 1'b0;
      end
      stop_at = items_sent + PhaseItems;
      while (items_sent < stop_at) random_frame();
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdicts_pending_o != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d byte transactions and %0d frame results over %0d limit settings",
             items_sent, results_seen_o, limits_written);
    $display("Frames: tagged, double tagged, IPv4 TCP/UDP, PROFINET/LLDP, short and truncated");
    if (fail_count_o == 0 && verdicts_pending_o == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/epc_pkg.sv
hw/rtl/epc_front.sv
hw/rtl/epc_fifo.sv
hw/rtl/epc_back.sv
hw/rtl/ethernet_ipv4_port_classifier_core.sv
tb/port_class_monitor.sv
tb/ethernet_ipv4_port_classifier_core_test.sv
